/* design/gwps_pkg.sv */
// shared types and constants for the grid word path search unit
package gwps_pkg;

  // fixed field widths
  localparam int REQ_W   = 2;
  localparam int COORD_W = 4;
  localparam int CH_W    = 8;
  localparam int POS_W   = 5;
  localparam int LEN_W   = 6;
  localparam int DIR_W   = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_GRID   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WORD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_IGNORE = 2'd3;

  // direction code meaning all four neighbours have been tried
  localparam logic [DIR_W-1:0] DIR_END = 3'd4;

  // neighbour order: column-1, column+1, row+1, row-1
  localparam logic signed [1:0] STEP_ROW [4] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_COL [4] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0};

  // commands from controller to datapath
  typedef struct packed {
    logic ld_grid;
    logic ld_word;
    logic start;
    logic init;
    logic try_nb;
    logic push;
    logic pop;
    logic pop_load;
    logic fin;
    logic fin_val;
  } gwps_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic trivial;
    logic bad;
    logic match;
    logic at_len;
    logic dir_done;
    logic nb_ok;
    logic last;
    logic out_free;
  } gwps_sts_t;

endpackage

/* design/gwps_ctrl.sv */
// search sequencer state machine for the grid word path search unit
module gwps_ctrl
  import gwps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] in_req_type,
  output logic             in_ready,
  input  gwps_sts_t        sts,
  output gwps_cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCHK = 6'b000010,
    S_STEP = 6'b000100,
    S_CMP  = 6'b001000,
    S_POPW = 6'b010000,
    S_FIN  = 6'b100000
  } gwps_state_t;

  gwps_state_t state_r, state_nxt;
  logic        res_r, res_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_GRID: cmd.ld_grid = 1'b1;
            REQ_WORD: cmd.ld_word = 1'b1;
            REQ_START: begin
              cmd.start = 1'b1;
              state_nxt = S_SCHK;
            end
            default: ;
          endcase
        end
      end
      S_SCHK: begin
        if (sts.trivial) begin
          res_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.bad || !sts.match) begin
          res_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.at_len) begin
          res_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.dir_done) begin
          cmd.pop = 1'b1;
          if (sts.last) begin
            res_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_POPW;
          end
        end else begin
          cmd.try_nb = 1'b1;
          if (sts.nb_ok) begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.push = 1'b1;
        end
        state_nxt = S_STEP;
      end
      S_POPW: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_STEP;
      end
      S_FIN: begin
        cmd.fin     = 1'b1;
        cmd.fin_val = res_r;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

/* design/gwps_dp.sv */
// grid and word stores, visited marks, path stack and result register
module gwps_dp
  import gwps_pkg::*;
#(
  parameter int GRID_DIM = 5,
  parameter int MAX_WORD = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] in_row,
  input  logic signed [COORD_W-1:0] in_col,
  input  logic [CH_W-1:0]           in_ch,
  input  logic [POS_W-1:0]          in_char_pos,
  input  logic [LEN_W-1:0]          in_word_len,
  input  gwps_cmd_t                 cmd,
  output gwps_sts_t                 sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      out_found
);

  localparam int CELLS  = GRID_DIM * GRID_DIM;
  localparam int CELL_W = $clog2(CELLS);
  localparam int RC_W   = $clog2(GRID_DIM);
  localparam int WA_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int DEP_W  = $clog2(MAX_WORD + 1);
  localparam int ENT_W  = 2 * RC_W + DIR_W;
  localparam logic [CELL_W-1:0] GD_C = CELL_W'(GRID_DIM);

  // row-major cell index
  function automatic logic [CELL_W-1:0] cell_of(logic [RC_W-1:0] r, logic [RC_W-1:0] c);
    return CELL_W'(CELL_W'(r) * GD_C + CELL_W'(c));
  endfunction

  // signed coordinate lies on the grid
  function automatic logic coord_ok(logic signed [COORD_W-1:0] v);
    return ($unsigned(v) < COORD_W'(GRID_DIM));
  endfunction

  logic [CH_W-1:0]  grid_mem [CELLS];
  logic [CH_W-1:0]  word_mem [MAX_WORD];
  logic [ENT_W-1:0] stk_mem  [MAX_WORD];

  logic signed [COORD_W-1:0] srow_r, scol_r;
  logic [LEN_W-1:0]          len_r;
  logic                      on_r;
  logic [RC_W-1:0]           cur_row_r, cur_col_r, nb_row_r, nb_col_r;
  logic [DIR_W-1:0]          cur_dir_r;
  logic [DEP_W-1:0]          depth_r;
  logic [CELLS-1:0]          vis_r, vis_nxt;
  logic [CH_W-1:0]           grid_q_r, word_q_r;
  logic [ENT_W-1:0]          stk_q_r;
  logic                      out_valid_r, out_found_r;

  logic                      in_on;
  logic [CELL_W-1:0]         in_cell, start_cell, cur_cell, nb_cell, nb_cell_r, grid_ra;
  logic signed [RC_W+1:0]    nr, nc;
  logic                      nb_on, nb_vis;
  logic [DEP_W-1:0]          dm1, dm2;
  logic [WA_W-1:0]           word_ra;

  // addresses
  assign in_on      = coord_ok(in_row) && coord_ok(in_col);
  assign in_cell    = in_on ? cell_of(in_row[RC_W-1:0], in_col[RC_W-1:0]) : '0;
  assign start_cell = cell_of(srow_r[RC_W-1:0], scol_r[RC_W-1:0]);
  assign cur_cell   = cell_of(cur_row_r, cur_col_r);
  assign nb_cell_r  = cell_of(nb_row_r, nb_col_r);
  assign dm1        = depth_r - DEP_W'(1);
  assign dm2        = depth_r - DEP_W'(2);

  // neighbour in the current direction
  assign nr      = $signed({2'b00, cur_row_r}) + (RC_W+2)'(STEP_ROW[cur_dir_r[1:0]]);
  assign nc      = $signed({2'b00, cur_col_r}) + (RC_W+2)'(STEP_COL[cur_dir_r[1:0]]);
  assign nb_on   = ($unsigned(nr) < (RC_W+2)'(GRID_DIM)) &&
                   ($unsigned(nc) < (RC_W+2)'(GRID_DIM));
  assign nb_cell = nb_on ? cell_of(nr[RC_W-1:0], nc[RC_W-1:0]) : '0;
  assign nb_vis  = nb_on ? vis_r[nb_cell] : 1'b1;

  assign grid_ra = cmd.start ? in_cell : nb_cell;
  assign word_ra = cmd.start ? '0 : depth_r[WA_W-1:0];

  // status toward the controller
  always_comb begin
    sts          = '0;
    sts.trivial  = (len_r == '0);
    sts.bad      = (len_r > LEN_W'(MAX_WORD)) || (len_r > LEN_W'(CELLS)) || !on_r;
    sts.match    = (grid_q_r == word_q_r);
    sts.at_len   = (LEN_W'(depth_r) == len_r);
    sts.dir_done = (cur_dir_r == DIR_END);
    sts.nb_ok    = !nb_vis;
    sts.last     = (depth_r == DEP_W'(1));
    sts.out_free = !out_valid_r || out_ready;
  end

  // grid store: load write, search read
  always_ff @(posedge clk) begin
    if (cmd.ld_grid && in_on) begin
      grid_mem[in_cell] <= in_ch;
    end
    if (cmd.start || cmd.try_nb) begin
      grid_q_r <= grid_mem[grid_ra];
    end
  end

  // word store
  always_ff @(posedge clk) begin
    if (cmd.ld_word && (LEN_W'(in_char_pos) < LEN_W'(MAX_WORD))) begin
      word_mem[in_char_pos[WA_W-1:0]] <= in_ch;
    end
    if (cmd.start || cmd.try_nb) begin
      word_q_r <= word_mem[word_ra];
    end
  end

  // path stack below the top entry
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[dm1[WA_W-1:0]] <= {cur_row_r, cur_col_r, cur_dir_r};
    end
    if (cmd.pop && !sts.last) begin
      stk_q_r <= stk_mem[dm2[WA_W-1:0]];
    end
  end

  // visited marks
  always_comb begin
    vis_nxt = vis_r;
    if (cmd.init) begin
      vis_nxt             = '0;
      vis_nxt[start_cell] = 1'b1;
    end else if (cmd.push) begin
      vis_nxt[nb_cell_r] = 1'b1;
    end else if (cmd.pop) begin
      vis_nxt[cur_cell] = 1'b0;
    end
  end

  // search control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r   <= '0;
      depth_r <= '0;
    end else begin
      vis_r <= vis_nxt;
      if (cmd.init) begin
        depth_r <= DEP_W'(1);
      end else if (cmd.push) begin
        depth_r <= depth_r + DEP_W'(1);
      end else if (cmd.pop) begin
        depth_r <= dm1;
      end
    end
  end

  // start item fields and top of path
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      srow_r <= in_row;
      scol_r <= in_col;
      len_r  <= in_word_len;
      on_r   <= in_on;
    end
    if (cmd.init) begin
      cur_row_r <= srow_r[RC_W-1:0];
      cur_col_r <= scol_r[RC_W-1:0];
      cur_dir_r <= '0;
    end else if (cmd.try_nb) begin
      cur_dir_r <= cur_dir_r + DIR_W'(1);
      nb_row_r  <= nr[RC_W-1:0];
      nb_col_r  <= nc[RC_W-1:0];
    end else if (cmd.push) begin
      cur_row_r <= nb_row_r;
      cur_col_r <= nb_col_r;
      cur_dir_r <= '0;
    end else if (cmd.pop_load) begin
      {cur_row_r, cur_col_r, cur_dir_r} <= stk_q_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin && sts.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.fin && sts.out_free) begin
      out_found_r <= cmd.fin_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

/* design/grid_word_path_search_unit.sv */
// top level of the grid word path search unit
//
//   channel | direction | ports                                            | moves
//   in_     | input     | in_valid/in_ready, req_type row col ch pos len  | load or start item
//   out_    | output    | out_valid/out_ready, out_found                   | one item per start
//
// a start that ends at once (empty word, too long, off the grid, first byte differs) goes
// to the result register without a search. a running search compares each on-grid,
// unvisited neighbour with the next word byte through the single grid read port,
// and backtracks once all four neighbours have been tried.
// reset is synchronous and clears control; grid and word bytes are undefined until loaded.
// the result waits in its own register; loads are taken while it waits, and a finished
// search holds in place until that register is free.
module grid_word_path_search_unit
  import gwps_pkg::*;
#(
  parameter int GRID_DIM = 5,
  parameter int MAX_WORD = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [REQ_W-1:0]          in_req_type,
  input  logic signed [COORD_W-1:0] in_row,
  input  logic signed [COORD_W-1:0] in_col,
  input  logic [CH_W-1:0]           in_ch,
  input  logic [POS_W-1:0]          in_char_pos,
  input  logic [LEN_W-1:0]          in_word_len,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found
);

  gwps_cmd_t cmd;
  gwps_sts_t sts;

  // sequencer
  gwps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // stores and search datapath
  gwps_dp #(
    .GRID_DIM (GRID_DIM),
    .MAX_WORD (MAX_WORD)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_ch       (in_ch),
    .in_char_pos (in_char_pos),
    .in_word_len (in_word_len),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_found   (out_found)
  );

endmodule

/* design/gwps_chk.sv */
// port-level checker for the grid word path search unit, with its bind
module gwps_chk
  import gwps_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [REQ_W-1:0]          in_req_type,
  input logic signed [COORD_W-1:0] in_row,
  input logic signed [COORD_W-1:0] in_col,
  input logic [CH_W-1:0]           in_ch,
  input logic [POS_W-1:0]          in_char_pos,
  input logic [LEN_W-1:0]          in_word_len,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_found
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("result changed or dropped while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a taken start item drops in_ready as its search begins
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == REQ_START |=> !in_ready)
    else $error("input taken during a search");

  // a load item yields no result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type != REQ_START && !out_valid |=> !out_valid)
    else $error("result without a start item");

  // an empty word is reported as found
  a_empty_found: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == REQ_START && in_word_len == '0 && !out_valid
    |-> ##3 (out_valid && out_found))
    else $error("empty word not reported as found");

endmodule

bind grid_word_path_search_unit gwps_chk u_gwps_chk (.*);
